// ===== hdl/orwa_pkg.sv =====
// ---------------------------------------------------------------------------
// orwa_pkg - shared definitions for the outlier rejecting weighted average
// Field widths, register indexes, reset values and divider step count.
// ---------------------------------------------------------------------------
`default_nettype none

package orwa_pkg;

    // Field widths
    localparam int SAMPLE_W   = 24;
    localparam int VALUE_W    = 25;
    localparam int LIMIT_W    = 23;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    // Register indexes
    localparam cfg_addr_t REG_ZERO_OFFSET_CH0 = 2'd0;
    localparam cfg_addr_t REG_ZERO_OFFSET_CH1 = 2'd1;
    localparam cfg_addr_t REG_OUTLIER_LIMIT   = 2'd2;

    // Reset value of the outlier limit
    localparam logic [LIMIT_W-1:0] RESET_OUTLIER_LIMIT = 23'd600000;

    // Quotient bits resolved per cycle by the constant divider
    localparam int DIV_STEPS = 4;

endpackage : orwa_pkg

`default_nettype wire

// ===== hdl/orwa_ram.sv =====
// ---------------------------------------------------------------------------
// orwa_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module orwa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : orwa_ram

`default_nettype wire

// ===== hdl/outlier_rejecting_weighted_average.sv =====
// ---------------------------------------------------------------------------
// outlier_rejecting_weighted_average - two-channel weighted smoothing filter
// Offset correction, outlier replacement and a linearly weighted average
// over a per-channel history held in one RAM.
// ---------------------------------------------------------------------------
// Each input word carries a 24-bit converter code (s_tdata) and a channel
// number (s_tuser). The channel's zero offset is subtracted; a corrected value
// whose magnitude exceeds the outlier limit is replaced by the newest stored
// sample of that channel. The value enters the channel's WINDOW_LEN-entry
// history, and one output word gives (newest + sum of (N-i)*history[i]) /
// (N(N-1)/2), truncated toward zero, with the channel in m_tuser. Both
// histories live in one RAM of 2*WINDOW_LEN entries addressed as circular
// buffers. One word is processed at a time: its history is walked through
// the single RAM read port with one multiply-accumulate per entry, followed
// by a constant divider that resolves four quotient bits per cycle. The
// output register lets the next word be accepted while a result still waits.
// After reset the RAM is cleared entry by entry, and no input word is taken
// until that is done. Configuration writes are taken at any time; an offset
// applies from the next word accepted, the limit from the next outlier test.
// ---------------------------------------------------------------------------
`default_nettype none

module outlier_rejecting_weighted_average #(
    parameter int WINDOW_LEN = 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [orwa_pkg::S_TDATA_W-1:0]     s_tdata,   // [23:0] sample
    input  wire logic                               s_tuser,   // [0] channel
    // Result stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [orwa_pkg::M_TDATA_W-1:0]     m_tdata,   // [24:0] filtered_value,
                                                               // [31:25] zero
    output logic                                    m_tuser,   // [0] result_channel
    // Configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire orwa_pkg::cfg_addr_t                cfg_addr,
    input  wire logic [orwa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Derived sizes
    localparam int WSUM      = WINDOW_LEN * (WINDOW_LEN - 1) / 2;
    localparam int PW        = $clog2(WINDOW_LEN);
    localparam int DEPTH     = 2 * WINDOW_LEN;
    localparam int AW        = $clog2(DEPTH);
    localparam int DEN_W     = $clog2(WSUM + 1);
    localparam int MAG_W     = orwa_pkg::SAMPLE_W + DEN_W;
    localparam int ACC_W     = MAG_W + 1;
    localparam int PROD_W    = orwa_pkg::SAMPLE_W + PW + 1;
    localparam int DIV_ITERS = (MAG_W + orwa_pkg::DIV_STEPS - 1) / orwa_pkg::DIV_STEPS;
    localparam int DIV_W     = DIV_ITERS * orwa_pkg::DIV_STEPS;
    localparam int ITW       = $clog2(DIV_ITERS + 1);
    localparam int SW        = orwa_pkg::SAMPLE_W;
    localparam int VW        = orwa_pkg::VALUE_W;

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_ABS   = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // Registers
    logic [2:0]                        state_reg, state_next;
    logic [AW-1:0]                     clr_reg, clr_next;
    logic [PW-1:0]                     head_reg [2];
    logic [PW-1:0]                     head_next [2];
    logic [SW-1:0]                     offset0_reg, offset0_next;
    logic [SW-1:0]                     offset1_reg, offset1_next;
    logic [orwa_pkg::LIMIT_W-1:0]      limit_reg, limit_next;
    logic                              ch_reg, ch_next;
    logic signed [VW-1:0]              diff_reg, diff_next;
    logic [PW-1:0]                     rptr_reg, rptr_next;
    logic [PW-1:0]                     rd_left_reg, rd_left_next;
    logic                              pend_reg, pend_next;
    logic                              first_reg, first_next;
    logic [PW-1:0]                     wt_reg, wt_next;
    logic signed [ACC_W-1:0]           acc_reg, acc_next;
    logic                              neg_reg, neg_next;
    logic [DIV_W-1:0]                  dq_reg, dq_next;
    logic [DEN_W-1:0]                  rem_reg, rem_next;
    logic [ITW-1:0]                    it_reg, it_next;
    logic                              m_valid_reg, m_valid_next;
    logic [VW-1:0]                     m_value_reg, m_value_next;
    logic                              m_chan_reg, m_chan_next;

    // RAM port signals
    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    logic [SW-1:0]                     ram_wdata;
    logic [AW-1:0]                     ram_raddr;
    logic [SW-1:0]                     ram_rdata;

    // Datapath temporaries
    logic signed [VW-1:0]              in_diff;
    logic [SW-1:0]                     in_offset;
    logic [VW-1:0]                     diff_mag;
    logic                              reject;
    logic signed [SW-1:0]              corrected;
    logic signed [PROD_W-1:0]          prod;
    logic signed [ACC_W-1:0]           acc_base;
    logic [PW-1:0]                     new_head;
    logic [DEN_W:0]                    rem_s;
    logic [DIV_W-1:0]                  dq_s;
    logic [DIV_W-1:0]                  quot;

    // Map a channel and ring position onto a RAM address
    function automatic logic [AW-1:0] ring_addr(input logic ch, input logic [PW-1:0] ptr);
        logic [AW-1:0] base;
        base = ch ? AW'(WINDOW_LEN) : '0;
        return base + AW'(ptr);
    endfunction

    // History store for both channels
    orwa_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Offset correction of the incoming word
    always_comb begin
        in_offset = s_tuser ? offset1_reg : offset0_reg;
        in_diff   = $signed({1'b0, s_tdata[SW-1:0]}) - $signed({1'b0, in_offset});
    end

    // Outlier test and multiply-accumulate on the word read back
    always_comb begin
        diff_mag  = diff_reg[VW-1] ? VW'(-diff_reg) : VW'(diff_reg);
        reject    = diff_mag > VW'(limit_reg);
        corrected = reject ? $signed(ram_rdata) : diff_reg[SW-1:0];
        prod      = $signed(ram_rdata) * $signed({1'b0, wt_reg});
        acc_base  = first_reg ? ACC_W'(corrected) : acc_reg;
        new_head  = (head_reg[ch_reg] == PW'(WINDOW_LEN - 1)) ? '0 : head_reg[ch_reg] + 1'b1;
    end

    // Restoring division by the weight sum, several bits per cycle
    always_comb begin
        rem_s = {1'b0, rem_reg};
        dq_s  = dq_reg;
        for (int k = 0; k < orwa_pkg::DIV_STEPS; k++) begin
            rem_s = {rem_s[DEN_W-1:0], dq_s[DIV_W-1]};
            dq_s  = {dq_s[DIV_W-2:0], 1'b0};
            if (rem_s >= (DEN_W+1)'(WSUM)) begin
                rem_s   = rem_s - (DEN_W+1)'(WSUM);
                dq_s[0] = 1'b1;
            end
        end
        quot = neg_reg ? DIV_W'(-dq_reg) : dq_reg;
    end

    // RAM address and write selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ring_addr(ch_reg, new_head);
        ram_wdata = corrected;
        ram_raddr = ring_addr(ch_reg, rptr_reg);
        if (state_reg == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end else if (state_reg == S_WALK && pend_reg && first_reg) begin
            ram_we = 1'b1;
        end
        if (state_reg == S_IDLE) begin
            ram_raddr = ring_addr(s_tuser, head_reg[s_tuser]);
        end
    end

    // Sequencer and next-state logic
    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        head_next    = head_reg;
        offset0_next = offset0_reg;
        offset1_next = offset1_reg;
        limit_next   = limit_reg;
        ch_next      = ch_reg;
        diff_next    = diff_reg;
        rptr_next    = rptr_reg;
        rd_left_next = rd_left_reg;
        pend_next    = 1'b0;
        first_next   = first_reg;
        wt_next      = wt_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        it_next      = it_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_value_next = m_value_reg;
        m_chan_next  = m_chan_reg;

        // Take configuration writes
        if (cfg_valid) begin
            unique case (cfg_addr)
                orwa_pkg::REG_ZERO_OFFSET_CH0: offset0_next = cfg_data[SW-1:0];
                orwa_pkg::REG_ZERO_OFFSET_CH1: offset1_next = cfg_data[SW-1:0];
                orwa_pkg::REG_OUTLIER_LIMIT:   limit_next   = cfg_data[orwa_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                // Latch the word and read the newest entry of its channel
                if (s_tvalid) begin
                    ch_next      = s_tuser;
                    diff_next    = in_diff;
                    rptr_next    = (head_reg[s_tuser] == '0) ? PW'(WINDOW_LEN - 1)
                                                             : head_reg[s_tuser] - 1'b1;
                    rd_left_next = PW'(WINDOW_LEN - 2);
                    pend_next    = 1'b1;
                    first_next   = 1'b1;
                    wt_next      = PW'(WINDOW_LEN - 1);
                    state_next   = S_WALK;
                end
            end
            S_WALK: begin
                // Issue the next history read
                if (rd_left_reg != '0) begin
                    pend_next    = 1'b1;
                    rd_left_next = rd_left_reg - 1'b1;
                    rptr_next    = (rptr_reg == '0) ? PW'(WINDOW_LEN - 1) : rptr_reg - 1'b1;
                end
                // Accumulate the word read back
                if (pend_reg) begin
                    acc_next   = acc_base + ACC_W'(prod);
                    first_next = 1'b0;
                    wt_next    = wt_reg - 1'b1;
                    if (first_reg) begin
                        head_next[ch_reg] = new_head;
                    end
                    if (wt_reg == PW'(1)) begin
                        state_next = S_ABS;
                    end
                end
            end
            S_ABS: begin
                // Split the sum into sign and magnitude
                neg_next   = acc_reg[ACC_W-1];
                dq_next    = acc_reg[ACC_W-1] ? DIV_W'(-acc_reg) : DIV_W'(acc_reg);
                rem_next   = '0;
                it_next    = ITW'(DIV_ITERS);
                state_next = S_DIV;
            end
            S_DIV: begin
                dq_next  = dq_s;
                rem_next = rem_s[DEN_W-1:0];
                it_next  = it_reg - 1'b1;
                if (it_reg == ITW'(1)) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // Load the output register once it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_value_next = quot[VW-1:0];
                    m_chan_next  = ch_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            head_reg[0] <= '0;
            head_reg[1] <= '0;
            offset0_reg <= '0;
            offset1_reg <= '0;
            limit_reg   <= orwa_pkg::RESET_OUTLIER_LIMIT;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            head_reg    <= head_next;
            offset0_reg <= offset0_next;
            offset1_reg <= offset1_next;
            limit_reg   <= limit_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ch_reg      <= ch_next;
        diff_reg    <= diff_next;
        rptr_reg    <= rptr_next;
        rd_left_reg <= rd_left_next;
        first_reg   <= first_next;
        wt_reg      <= wt_next;
        acc_reg     <= acc_next;
        neg_reg     <= neg_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        it_reg      <= it_next;
        m_value_reg <= m_value_next;
        m_chan_reg  <= m_chan_next;
    end

    // Port drive
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(orwa_pkg::M_TDATA_W - VW){1'b0}}, m_value_reg};
    assign m_tuser   = m_chan_reg;

endmodule : outlier_rejecting_weighted_average

`default_nettype wire

// ===== hdl/orwa_checker.sv =====
// ---------------------------------------------------------------------------
// orwa_checker - port-level checks for the weighted average filter
// Watches the input and result stream ports; bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module orwa_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [orwa_pkg::M_TDATA_W-1:0]  m_tdata
);

    // Hold a stalled result word
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One word in flight: input closes after each accepted word
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a word is in progress");

    // Padding above the filtered value stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[orwa_pkg::M_TDATA_W-1:orwa_pkg::VALUE_W] == '0)
        else $error("result padding bits not zero");

endmodule : orwa_checker

bind outlier_rejecting_weighted_average orwa_checker u_orwa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
